// ===== src/crtdpf_pkg.sv =====
// ----------------------------------------------------------------------------
// CRT display-profile filter package
// Shared types, constants and codes for the filter front, queue and back.
// ----------------------------------------------------------------------------
package crtdpf_pkg;

    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 3;
    localparam int PIXEL_W = CHAN_W * NUM_CH;
    localparam int MODE_W  = 3;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    localparam logic [3:0] DARK_SCAN = 4'd11;
    localparam logic [3:0] DARK_SOFT = 4'd12;

    typedef enum logic [MODE_W-1:0] {
        MODE_RAW       = 3'd0,
        MODE_SCAN      = 3'd1,
        MODE_SOFT      = 3'd2,
        MODE_SOFT_SCAN = 3'd3,
        MODE_COMPOSITE = 3'd4
    } mode_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t left;
        pixel_t mid;
        pixel_t right;
        logic   odd;
        logic   line_end;
    } job_t;

    typedef struct packed {
        job_t slot0;
        job_t slot1;
        logic two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== src/crtdpf_front.sv =====
// ----------------------------------------------------------------------------
// CRT filter front
// Accepts pixels, tracks row neighbors and parity, and forms filter jobs.
// ----------------------------------------------------------------------------
module crtdpf_front
    import crtdpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIXEL_W-1:0]   s_tdata,   // blue, green, red
    input  logic                 s_tlast,
    input  logic                 s_tuser,   // frame_start
    input  q_status_t            q_stat,
    output logic                 push,
    output entry_t               push_entry
);

    pixel_t left_reg, left_next;
    pixel_t held_reg, held_next;
    logic   valid_reg, valid_next;
    logic   ls_reg, ls_next;
    logic   odd_reg, odd_next;

    logic   accept;
    logic   has_a;
    logic   has_b;
    job_t   job_a;
    job_t   job_b;
    pixel_t cur;

    assign cur      = s_tdata;
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        left_next  = left_reg;
        held_next  = held_reg;
        valid_next = valid_reg;
        ls_next    = ls_reg;
        odd_next   = odd_reg;
        has_a      = 1'b0;
        has_b      = 1'b0;
        job_a      = '0;
        job_b      = '0;

        if (s_tuser)
        begin
            if (valid_reg)
            begin
                has_a          = 1'b1;
                job_a.left     = ls_reg ? held_reg : left_reg;
                job_a.mid      = held_reg;
                job_a.right    = held_reg;
                job_a.odd      = odd_reg;
                job_a.line_end = 1'b1;
            end
            odd_next = 1'b0;
            ls_next  = 1'b1;
        end
        else if (valid_reg)
        begin
            has_a          = 1'b1;
            job_a.left     = ls_reg ? held_reg : left_reg;
            job_a.mid      = held_reg;
            job_a.right    = cur;
            job_a.odd      = odd_reg;
            job_a.line_end = 1'b0;
            left_next      = held_reg;
            ls_next        = 1'b0;
        end

        held_next  = cur;
        valid_next = 1'b1;

        if (s_tlast)
        begin
            has_b          = 1'b1;
            job_b.left     = ls_next ? cur : left_next;
            job_b.mid      = cur;
            job_b.right    = cur;
            job_b.odd      = odd_next;
            job_b.line_end = 1'b1;
            valid_next     = 1'b0;
            ls_next        = 1'b1;
            odd_next       = !odd_next;
        end
    end

    always_comb
    begin
        push             = accept && (has_a || has_b);
        push_entry.slot0 = has_a ? job_a : job_b;
        push_entry.slot1 = job_b;
        push_entry.two   = has_a && has_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            held_reg  <= '0;
            valid_reg <= 1'b0;
            ls_reg    <= 1'b1;
            odd_reg   <= 1'b0;
        end
        else if (accept)
        begin
            left_reg  <= left_next;
            held_reg  <= held_next;
            valid_reg <= valid_next;
            ls_reg    <= ls_next;
            odd_reg   <= odd_next;
        end
    end

endmodule

// ===== src/crtdpf_queue.sv =====
// ----------------------------------------------------------------------------
// CRT filter job queue
// Short FIFO of job entries between the front and the back.
// ----------------------------------------------------------------------------
module crtdpf_queue
    import crtdpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  entry_t     push_entry,
    input  logic       pop,
    output entry_t     head,
    output q_status_t  q_stat
);

    entry_t           mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = (count_reg == QCW'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/crtdpf_back.sv =====
// ----------------------------------------------------------------------------
// CRT filter back
// Applies the selected display profile to each job and drives the output.
// ----------------------------------------------------------------------------
module crtdpf_back
    import crtdpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MODE_W-1:0]    mode,
    input  entry_t               head,
    input  q_status_t            q_stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIXEL_W-1:0]   m_tdata,   // blue, green, red
    output logic                 m_tlast,   // out_line_end
    output logic                 m_tuser    // last_result
);

    function automatic logic [CHAN_W-1:0] darken(
        input logic [CHAN_W-1:0] v,
        input logic [3:0]        num
    );
        logic [CHAN_W+4-1:0] prod;
        begin
            prod   = {4'd0, v} * {{CHAN_W{1'b0}}, num} + (CHAN_W+4)'(8);
            darken = prod[CHAN_W+4-1:4];
        end
    endfunction

    function automatic logic [CHAN_W-1:0] chan_filter(
        input logic [MODE_W-1:0] md,
        input int                ch,
        input logic [CHAN_W-1:0] l,
        input logic [CHAN_W-1:0] m,
        input logic [CHAN_W-1:0] r,
        input logic              odd
    );
        logic [CHAN_W+3-1:0] soft_sum;
        logic [CHAN_W+2-1:0] blend;
        logic [CHAN_W-1:0]   blur_val;
        logic [CHAN_W-1:0]   res;
        begin
            soft_sum = (CHAN_W+3)'(l) + ((CHAN_W+3)'(m) << 2) + ((CHAN_W+3)'(m) << 1)
                     + (CHAN_W+3)'(r) + (CHAN_W+3)'(4);
            blur_val = soft_sum[CHAN_W+3-1:3];
            blend    = (CHAN_W+2)'(m) + ((CHAN_W+2)'(m) << 1) + (CHAN_W+2)'(2)
                     + ((ch == CH_BLUE) ? (CHAN_W+2)'(l) : (CHAN_W+2)'(r));
            case (md)
                MODE_SCAN:      res = odd ? darken(m, DARK_SCAN) : m;
                MODE_SOFT:      res = blur_val;
                MODE_SOFT_SCAN: res = odd ? darken(blur_val, DARK_SOFT) : blur_val;
                MODE_COMPOSITE: res = (ch == CH_GREEN) ? blur_val : blend[CHAN_W+2-1:2];
                default:        res = m;
            endcase
            chan_filter = res;
        end
    endfunction

    logic                sel_reg, sel_next;
    logic                valid_reg, valid_next;
    logic [PIXEL_W-1:0]  data_reg;
    logic                last_reg;
    logic                user_reg;

    job_t                job;
    logic                final_slot;
    logic                take;
    logic [PIXEL_W-1:0]  filt;

    assign job        = sel_reg ? head.slot1 : head.slot0;
    assign final_slot = !head.two || sel_reg;
    assign take       = !q_stat.empty && (!valid_reg || m_tready);
    assign pop        = take && final_slot;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            filt[c*CHAN_W +: CHAN_W] = chan_filter(mode, c,
                                                   job.left[c*CHAN_W +: CHAN_W],
                                                   job.mid[c*CHAN_W +: CHAN_W],
                                                   job.right[c*CHAN_W +: CHAN_W],
                                                   job.odd);
        end
    end

    always_comb
    begin
        sel_next   = sel_reg;
        valid_next = valid_reg;
        if (take)
        begin
            sel_next   = !final_slot;
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= filt;
            last_reg <= job.line_end;
            user_reg <= final_slot;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

// ===== src/crt_display_profile_filter.sv =====
// The pixel that completes a result pushes its job into the job queue; the back filters it into the output register.
// Throughput: one pixel per cycle while the job queue is not full; a pixel that closes a row behind a held pixel
// yields two results, which leave the output register one per cycle while the output is ready.
// A four-entry job queue between the front and the output stage absorbs output stalls.
// Reset: clears row state, holds no pixel, empties the queue and sets the mode to raw.
// ----------------------------------------------------------------------------
// CRT display-profile filter
// Scanline, horizontal blur and composite post-processing of a BGR pixel stream.
// ----------------------------------------------------------------------------
module crt_display_profile_filter
    import crtdpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [MODE_W-1:0]    cfg_wr_data,  // display_mode
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIXEL_W-1:0]   s_tdata,      // in_blue, in_green, in_red
    input  logic                 s_tlast,      // line_end
    input  logic                 s_tuser,      // frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIXEL_W-1:0]   m_tdata,      // out_blue, out_green, out_red
    output logic                 m_tlast,      // out_line_end
    output logic                 m_tuser       // last_result
);

    logic [MODE_W-1:0] mode_reg;
    logic              push;
    entry_t            push_entry;
    logic              pop;
    entry_t            head;
    q_status_t         q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RAW;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    crtdpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    crtdpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    crtdpf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_full_implies_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid
    ) else $error("queue full while output register is empty");

    a_pair_ends_row: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid && m_tuser && m_tlast
    ) else $error("first of a result pair not followed by a row-ending result");

    a_queue_not_stuck: assert property (
        @(posedge clk) disable iff (!rst_n)
        !q_stat.empty && !m_tvalid |=> m_tvalid
    ) else $error("pending job not moved to the output register");

endmodule

// ===== dv/crt_display_profile_filter_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRT display-profile filter checker
// Watches the pixel, result and configuration channels, keeps its own copy of
// the row state and display mode, predicts every filtered pixel and compares
// each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module crt_display_profile_filter_chk
    import crtdpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [MODE_W-1:0]    cfg_wr_data,  // display_mode
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [PIXEL_W-1:0]   s_tdata,      // in_blue, in_green, in_red
    input  logic                 s_tlast,      // line_end
    input  logic                 s_tuser,      // frame_start
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [PIXEL_W-1:0]   m_tdata,      // out_blue, out_green, out_red
    input  logic                 m_tlast,      // out_line_end
    input  logic                 m_tuser,      // last_result
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        pixel_t px;
        logic   line_end;
        logic   last;
    } shaded_t;

    shaded_t           shaded_q[$];
    logic [MODE_W-1:0] mode       = MODE_RAW;
    pixel_t            left_px    = '0;
    pixel_t            held_px    = '0;
    logic              held_ok    = 1'b0;
    logic              held_first = 1'b1;
    logic              odd_row    = 1'b0;
    int                fail_count = 0;

    function automatic int unsigned dim(int unsigned v, int unsigned num);
        return (v * num + 8) / 16;
    endfunction

    function automatic int unsigned blur(int unsigned l, int unsigned m, int unsigned r);
        return (l + 6 * m + r + 4) >> 3;
    endfunction

    function automatic pixel_t shade(pixel_t l, pixel_t m, pixel_t r, logic odd);
        int unsigned lv, mv, rv, v;
        pixel_t      res;
        res = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            lv = 32'(l[c*CHAN_W +: CHAN_W]);
            mv = 32'(m[c*CHAN_W +: CHAN_W]);
            rv = 32'(r[c*CHAN_W +: CHAN_W]);
            case (mode)
                MODE_SCAN:
                    v = odd ? dim(mv, 32'(DARK_SCAN)) : mv;
                MODE_SOFT:
                    v = blur(lv, mv, rv);
                MODE_SOFT_SCAN:
                begin
                    v = blur(lv, mv, rv);
                    if (odd)
                        v = dim(v, 32'(DARK_SOFT));
                end
                MODE_COMPOSITE:
                begin
                    if (c == CH_BLUE)
                        v = (3 * mv + lv + 2) >> 2;
                    else if (c == CH_GREEN)
                        v = blur(lv, mv, rv);
                    else
                        v = (3 * mv + rv + 2) >> 2;
                end
                default:
                    v = mv;
            endcase
            res[c*CHAN_W +: CHAN_W] = v[CHAN_W-1:0];
        end
        return res;
    endfunction

    function automatic void queue_shaded(pixel_t px, logic le);
        shaded_t item;
        item = '{px: px, line_end: le, last: 1'b0};
        shaded_q.push_back(item);
    endfunction

    function automatic void predict_pixel(pixel_t cur, logic le, logic fs);
        int queued;
        queued = shaded_q.size();
        if (fs)
        begin
            if (held_ok)
            begin
                queue_shaded(shade(held_first ? held_px : left_px, held_px, held_px, odd_row),
                             1'b1);
                held_ok = 1'b0;
            end
            odd_row    = 1'b0;
            held_first = 1'b1;
        end
        else if (held_ok)
        begin
            queue_shaded(shade(held_first ? held_px : left_px, held_px, cur, odd_row), 1'b0);
            left_px    = held_px;
            held_first = 1'b0;
        end
        held_px = cur;
        held_ok = 1'b1;
        if (le)
        begin
            queue_shaded(shade(held_first ? cur : left_px, cur, cur, odd_row), 1'b1);
            held_ok    = 1'b0;
            held_first = 1'b1;
            odd_row    = !odd_row;
        end
        if (shaded_q.size() > queued)
            shaded_q[shaded_q.size()-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result();
        shaded_t want;
        string   names [NUM_CH];
        names = '{"blue", "green", "red"};
        if (shaded_q.size() == 0)
        begin
            report_mismatch("result with nothing pending", 32'(m_tdata), 0);
            return;
        end
        want = shaded_q.pop_front();
        for (int c = 0; c < NUM_CH; c++)
            if (m_tdata[c*CHAN_W +: CHAN_W] !== want.px[c*CHAN_W +: CHAN_W])
                report_mismatch(names[c], 32'(m_tdata[c*CHAN_W +: CHAN_W]),
                                32'(want.px[c*CHAN_W +: CHAN_W]));
        if (m_tlast !== want.line_end)
            report_mismatch("line end", 32'(m_tlast), 32'(want.line_end));
        if (m_tuser !== want.last)
            report_mismatch("last result", 32'(m_tuser), 32'(want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shaded_q.delete();
            mode        = MODE_RAW;
            left_px     = '0;
            held_px     = '0;
            held_ok     = 1'b0;
            held_first  = 1'b1;
            odd_row     = 1'b0;
            outstanding <= 0;
            mismatches  <= fail_count;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_wr_en)
                mode = cfg_wr_data;
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata, s_tlast, s_tuser);
            outstanding <= shaded_q.size();
            mismatches  <= fail_count;
        end
    end

endmodule

// ===== dv/crt_display_profile_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRT display-profile filter testbench
// Drives rasters of BGR pixels through every display mode: a directed set of
// row-edge and frame-start cases, then random frames with broken rows and
// noise, random idling on both sides and long output hold-offs.
// ----------------------------------------------------------------------------
module crt_display_profile_filter_tb;
    import crtdpf_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int IDLE_PCT      = 35;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 80;
    localparam int CALM_PHASE    = 5;
    localparam int HOLD_PHASE_A  = 3;
    localparam int HOLD_PHASE_B  = 7;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam pixel_t BLACK = '0;
    localparam pixel_t WHITE = '1;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [MODE_W-1:0] cfg_wr_data = MODE_RAW;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    pixel_t            s_tdata     = '0;
    logic              s_tlast     = 1'b0;
    logic              s_tuser     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    pixel_t            m_tdata;
    logic              m_tlast;
    logic              m_tuser;
    int                mismatches;
    int                outstanding;

    logic tx_calm       = 1'b0;
    logic rx_calm       = 1'b0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   cycle_count   = 0;

    always #5 clk = ~clk;

    crt_display_profile_filter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    crt_display_profile_filter_chk u_chk (.*);

    function automatic logic [CHAN_W-1:0] any_channel();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return CHAN_W'($urandom);
    endfunction

    function automatic pixel_t any_pixel();
        return {any_channel(), any_channel(), any_channel()};
    endfunction

    function automatic logic [MODE_W-1:0] phase_mode(int p);
        case (p)
            0:       return MODE_SPARE_HI;
            1:       return MODE_SCAN;
            2:       return MODE_SOFT;
            3:       return MODE_SOFT_SCAN;
            4:       return MODE_COMPOSITE;
            5:       return MODE_RAW;
            6:       return MODE_SPARE_LO;
            7:       return MODE_SOFT_SCAN;
            8:       return MODE_W'($urandom_range(MODE_SPARE_HI));
            default: return MODE_COMPOSITE;
        endcase
    endfunction

    task automatic send_pixel(pixel_t px, logic le, logic fs);
        if (!tx_calm)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= le;
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_row(int width, logic fs, logic close);
        for (int i = 0; i < width; i++)
            send_pixel(any_pixel(), close && (i == width - 1), fs && (i == 0));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_directed();
        write_mode(MODE_COMPOSITE);
        send_pixel(BLACK, 1'b1, 1'b1);
        send_pixel(WHITE, 1'b1, 1'b0);
        send_pixel(BLACK, 1'b0, 1'b0);
        send_pixel(WHITE, 1'b0, 1'b0);
        send_pixel(BLACK, 1'b1, 1'b0);
        // pending pixel closed by a frame start
        send_pixel(WHITE, 1'b0, 1'b0);
        send_pixel(24'h00ff01, 1'b0, 1'b0);
        send_pixel(24'h80fe7f, 1'b0, 1'b1);
        send_pixel(24'hff00fe, 1'b1, 1'b0);
        wait_idle();
        write_mode(MODE_SOFT_SCAN);
        send_pixel(WHITE, 1'b0, 1'b0);
        send_pixel(24'h7f807f, 1'b0, 1'b0);
        send_pixel(WHITE, 1'b1, 1'b0);
        send_pixel(WHITE, 1'b0, 1'b0);
        // held pixel emitted after a mode change
        wait_idle();
        write_mode(MODE_SCAN);
        send_pixel(BLACK, 1'b1, 1'b0);
        send_pixel(WHITE, 1'b1, 1'b0);
        wait_idle();
        write_mode(MODE_SOFT);
        send_pixel(WHITE, 1'b0, 1'b1);
        send_pixel(BLACK, 1'b1, 1'b0);
    endtask

    task automatic run_random(int p);
        int sent, width, kind;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            if ((p == HOLD_PHASE_A || p == HOLD_PHASE_B) && sent == 0)
                hold_requests <= hold_requests + 1;
            kind = $urandom_range(99);
            if (kind < 75)
            begin
                width = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                send_row(width, (sent == 0) || ($urandom_range(5) == 0), 1'b1);
            end
            else if (kind < 90)
            begin
                width = $urandom_range(5, 1);
                send_row(width, $urandom_range(3) == 0, 1'b0);
            end
            else
            begin
                width = 1;
                send_pixel(any_pixel(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            sent += width;
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_mode(phase_mode(p));
            tx_calm = (p == CALM_PHASE);
            rx_calm <= (p == CALM_PHASE);
            run_random(p);
        end
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
